@@ rtl/tal_pkg.sv @@
package tal_pkg;

    // Field widths of the stream items
    localparam int SAMPLE_W = 12;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 7;
    localparam int PRESS_W  = 12;
    localparam int BLINK_W  = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 3;

    // Press counter saturation value
    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

    // Special display patterns, bit0 = segment a
    localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;
    localparam logic [SEG_W-1:0] SEG_C     = 7'h39;
    localparam logic [SEG_W-1:0] SEG_L     = 7'h38;
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARN_LEVEL   = 3'd0,
        CFG_ALARM_LEVEL  = 3'd1,
        CFG_LOCK_LEVEL   = 3'd2,
        CFG_LONG_PRESS   = 3'd3,
        CFG_MIN_PRESS    = 3'd4,
        CFG_SLOW_BLINK   = 3'd5,
        CFG_MEDIUM_BLINK = 3'd6,
        CFG_FAST_BLINK   = 3'd7
    } t_cfg_idx;

    // Seven-segment pattern of a decimal digit
    function automatic logic [SEG_W-1:0] digit_segs(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/temperature_alarm_lock_controller_top.sv @@
// Over-temperature alarm and lock controller. Each input transfer is one 1 ms
// tick carrying a 12-bit converter sample and the button level; it produces
// exactly one result carrying the display segments, LEDs, cooler, buzzer, the
// scaled digit and the lock and maintenance flags. All state is updated in the
// same cycle an input is transferred and the result sits in an output
// register, so the block takes one item per clock cycle; input is
// refused only while a result waits and the output side is
// stalled. Thresholds and blink periods come from the write-only register
// port, which should be written while no tick is in flight.
module temperature_alarm_lock_controller_top #(
    parameter int ADC_RANGE           = 4096,
    parameter int PHASE_TICKS         = 500,
    parameter int COOLDOWN_BLINKS     = 6,
    parameter int COOLDOWN_HALF_TICKS = 250
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata from bit 0: adc_sample[11:0], button_down[12], zero pad
    input  logic [tal_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // master side
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata from bit 0: segments[6:0], green_led[7], yellow_led[8], red_led[9],
    // cooler_on[10], buzzer[11], level_digit[15:12], locked_flag[16],
    // maintenance_flag[17], zero pad
    output logic [tal_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [tal_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tal_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tal_pkg::*;

    localparam int PH_W   = $clog2(PHASE_TICKS + 1);
    localparam int CD_W   = $clog2(2 * COOLDOWN_BLINKS + 1);
    localparam int PROD_W = 16;
    localparam int THR_W  = $clog2(9 * ADC_RANGE + 1);
    localparam int CMP_W  = (THR_W > PROD_W) ? THR_W : PROD_W;
    localparam logic [PH_W-1:0]    PHASE_END = PH_W'(PHASE_TICKS);
    localparam logic [CD_W-1:0]    CD_START  = CD_W'(2 * COOLDOWN_BLINKS);
    localparam logic [BLINK_W:0]   CD_HALF   = (BLINK_W + 1)'(COOLDOWN_HALF_TICKS);

    // configuration registers
    logic [DIGIT_W-1:0] r_warn_level, r_alarm_level, r_lock_level;
    logic [PRESS_W-1:0] r_long_press_ticks, r_min_press_ticks;
    logic [BLINK_W-1:0] r_slow_blink_ticks, r_medium_blink_ticks, r_fast_blink_ticks;

    // controller state
    logic               r_maintenance_mode, n_maintenance_mode;
    logic               r_lock_latched, n_lock_latched;
    logic               r_alarm_muted, n_alarm_muted;
    logic [PRESS_W-1:0] r_press_ticks, n_press_ticks;
    logic               r_long_press_taken, n_long_press_taken;
    logic [PH_W-1:0]    r_phase_count, n_phase_count;
    logic               r_phase_half, n_phase_half;
    logic [BLINK_W-1:0] r_blink_count, n_blink_count;
    logic               r_blink_on, n_blink_on;
    logic               r_buzzer_level, n_buzzer_level;
    logic [CD_W-1:0]    r_cooldown_count, n_cooldown_count;
    logic               r_cooling_active, n_cooling_active;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic in_xfer;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_level         <= 4'd4;
            r_alarm_level        <= 4'd7;
            r_lock_level         <= 4'd9;
            r_long_press_ticks   <= 12'd2000;
            r_min_press_ticks    <= 12'd50;
            r_slow_blink_ticks   <= 9'd500;
            r_medium_blink_ticks <= 9'd200;
            r_fast_blink_ticks   <= 9'd60;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WARN_LEVEL:   r_warn_level         <= i_cfg_data[DIGIT_W-1:0];
                CFG_ALARM_LEVEL:  r_alarm_level        <= i_cfg_data[DIGIT_W-1:0];
                CFG_LOCK_LEVEL:   r_lock_level         <= i_cfg_data[DIGIT_W-1:0];
                CFG_LONG_PRESS:   r_long_press_ticks   <= i_cfg_data[PRESS_W-1:0];
                CFG_MIN_PRESS:    r_min_press_ticks    <= i_cfg_data[PRESS_W-1:0];
                CFG_SLOW_BLINK:   r_slow_blink_ticks   <= i_cfg_data[BLINK_W-1:0];
                CFG_MEDIUM_BLINK: r_medium_blink_ticks <= i_cfg_data[BLINK_W-1:0];
                CFG_FAST_BLINK:   r_fast_blink_ticks   <= i_cfg_data[BLINK_W-1:0];
            endcase
        end
    end

    // one tick of work: digit, phase timer, button, then display and indicators
    always_comb begin
        logic [SAMPLE_W-1:0] sample;
        logic                btn;
        logic [CMP_W-1:0]    prod;
        logic [DIGIT_W-1:0]  digit;
        logic [PH_W:0]       phase_inc;
        logic [BLINK_W:0]    blink_inc;
        logic [BLINK_W-1:0]  half;
        logic [SEG_W-1:0]    segs;
        logic                green, yellow, red, cooler, sound;

        sample = s_axis_tdata[SAMPLE_W-1:0];
        btn    = s_axis_tdata[SAMPLE_W];

        // digit = sample*10/ADC_RANGE, saturated at 9, by threshold compares
        prod  = CMP_W'(PROD_W'(sample) * PROD_W'(10));
        digit = '0;
        for (int k = 1; k < 10; k++) begin
            if (prod >= CMP_W'(k * ADC_RANGE)) digit = DIGIT_W'(k);
        end

        n_maintenance_mode = r_maintenance_mode;
        n_lock_latched     = r_lock_latched;
        n_alarm_muted      = r_alarm_muted;
        n_press_ticks      = r_press_ticks;
        n_long_press_taken = r_long_press_taken;
        n_phase_count      = r_phase_count;
        n_phase_half       = r_phase_half;
        n_blink_count      = r_blink_count;
        n_blink_on         = r_blink_on;
        n_cooldown_count   = r_cooldown_count;
        n_cooling_active   = r_cooling_active;
        segs   = SEG_BLANK;
        green  = 1'b0;
        yellow = 1'b0;
        red    = 1'b0;
        cooler = 1'b0;
        sound  = 1'b0;
        half   = r_slow_blink_ticks;
        blink_inc = '0;

        // phase timer
        phase_inc = {1'b0, r_phase_count} + 1'b1;
        if (phase_inc >= {1'b0, PHASE_END}) begin
            n_phase_count = '0;
            n_phase_half  = !r_phase_half;
        end else begin
            n_phase_count = phase_inc[PH_W-1:0];
        end

        // button
        priority if (r_cooling_active) begin
            n_press_ticks      = '0;
            n_long_press_taken = 1'b0;
        end else if (btn) begin
            if (r_press_ticks != PRESS_MAX) n_press_ticks = r_press_ticks + 1'b1;
            if (!r_long_press_taken && n_press_ticks > r_long_press_ticks) begin
                n_long_press_taken = 1'b1;
                n_maintenance_mode = !r_maintenance_mode;
                n_lock_latched     = 1'b0;
                n_alarm_muted      = 1'b0;
            end
        end else begin
            // short press on release
            if (r_press_ticks != '0 && !r_long_press_taken &&
                r_press_ticks > r_min_press_ticks && !r_maintenance_mode) begin
                if (r_lock_latched) begin
                    if (digit < r_alarm_level) begin
                        n_cooling_active = 1'b1;
                        n_cooldown_count = CD_START;
                        n_blink_count    = '0;
                        n_blink_on       = 1'b1;
                    end
                end else begin
                    n_alarm_muted = !r_alarm_muted;
                end
            end
            n_press_ticks      = '0;
            n_long_press_taken = 1'b0;
        end

        // operation
        priority if (n_cooling_active) begin
            segs      = n_blink_on ? SEG_C : SEG_BLANK;
            cooler    = 1'b1;
            blink_inc = {1'b0, n_blink_count} + 1'b1;
            if (blink_inc >= CD_HALF) begin
                n_blink_count = '0;
                n_blink_on    = !n_blink_on;
                if (n_cooldown_count != '0) n_cooldown_count = n_cooldown_count - 1'b1;
                if (n_cooldown_count == '0) begin
                    n_cooling_active = 1'b0;
                    n_lock_latched   = 1'b0;
                    n_alarm_muted    = 1'b0;
                    n_blink_on       = 1'b0;
                end
            end else begin
                n_blink_count = blink_inc[BLINK_W-1:0];
            end
        end else if (n_maintenance_mode) begin
            segs   = SEG_DASH;
            yellow = !n_phase_half;
        end else begin
            if (digit >= r_lock_level) n_lock_latched = 1'b1;
            if (n_lock_latched) segs = n_phase_half ? SEG_BLANK : SEG_L;
            else                segs = digit_segs(digit);
            priority if (digit >= r_alarm_level || n_lock_latched) begin
                cooler = 1'b1;
                if (digit == 4'd8) half = r_medium_blink_ticks;
                if (digit >= r_lock_level || n_lock_latched) half = r_fast_blink_ticks;
                if (half == '0) half = BLINK_W'(1);
                blink_inc = {1'b0, n_blink_count} + 1'b1;
                if (blink_inc >= {1'b0, half}) begin
                    n_blink_count = '0;
                    n_blink_on    = !n_blink_on;
                end else begin
                    n_blink_count = blink_inc[BLINK_W-1:0];
                end
                if (n_blink_on) begin
                    red   = 1'b1;
                    sound = !n_alarm_muted;
                end
            end else if (digit >= r_warn_level) begin
                yellow        = 1'b1;
                n_alarm_muted = 1'b0;
            end else begin
                green         = 1'b1;
                n_alarm_muted = 1'b0;
            end
        end

        n_buzzer_level = sound ? !r_buzzer_level : 1'b0;

        n_out_data = {6'd0, n_maintenance_mode, n_lock_latched, digit, n_buzzer_level,
                      cooler, red, yellow, green, segs};
    end

    // state and result update on input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maintenance_mode <= 1'b0;
            r_lock_latched     <= 1'b0;
            r_alarm_muted      <= 1'b0;
            r_press_ticks      <= '0;
            r_long_press_taken <= 1'b0;
            r_phase_count      <= '0;
            r_phase_half       <= 1'b0;
            r_blink_count      <= '0;
            r_blink_on         <= 1'b0;
            r_buzzer_level     <= 1'b0;
            r_cooldown_count   <= '0;
            r_cooling_active   <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_maintenance_mode <= n_maintenance_mode;
                r_lock_latched     <= n_lock_latched;
                r_alarm_muted      <= n_alarm_muted;
                r_press_ticks      <= n_press_ticks;
                r_long_press_taken <= n_long_press_taken;
                r_phase_count      <= n_phase_count;
                r_phase_half       <= n_phase_half;
                r_blink_count      <= n_blink_count;
                r_blink_on         <= n_blink_on;
                r_buzzer_level     <= n_buzzer_level;
                r_cooldown_count   <= n_cooldown_count;
                r_cooling_active   <= n_cooling_active;
                r_out_valid        <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    // cooldown only runs from a latched lock and holds it until the end
    a_cool_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cooling_active |-> r_lock_latched)
        else $error("cooldown active without lock");

    // cooldown never starts or runs in maintenance mode
    a_cool_maint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cooling_active && r_maintenance_mode))
        else $error("cooldown during maintenance");

    // halves left stay within the programmed count
    a_cd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cooldown_count <= CD_START)
        else $error("cooldown count out of range");

    // phase counter wraps before its period
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase_count < PHASE_END)
        else $error("phase counter out of range");

endmodule

@@ verif/temperature_alarm_lock_controller_top_tb.sv @@
module temperature_alarm_lock_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tal_pkg::*;

    localparam int ADC_RANGE           = 4096;
    localparam int PHASE_TICKS         = 500;
    localparam int COOLDOWN_BLINKS     = 6;
    localparam int COOLDOWN_HALF_TICKS = 250;
    localparam int STALL_LIMIT         = 3000;   // cycles without any transfer
    localparam int DRAIN_CYCLES        = 4;      // covers the output register plus margin

    localparam logic [SEG_W-1:0] DIGIT_PATTERN [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Thresholds and blink periods as held in the register file
    typedef struct packed {
        logic [DIGIT_W-1:0] warn;
        logic [DIGIT_W-1:0] alarm;
        logic [DIGIT_W-1:0] lock;
        logic [PRESS_W-1:0] long_press;
        logic [PRESS_W-1:0] min_press;
        logic [BLINK_W-1:0] slow;
        logic [BLINK_W-1:0] mid;
        logic [BLINK_W-1:0] fast;
    } t_alarm_cfg;

    // Controller state carried from tick to tick
    typedef struct packed {
        logic               maint;
        logic               locked;
        logic               muted;
        logic [PRESS_W-1:0] press;
        logic               long_taken;
        logic [BLINK_W-1:0] phase_cnt;
        logic               phase_half;
        logic [BLINK_W-1:0] blink_cnt;
        logic               blink_on;
        logic               buzz;
        logic [11:0]        cool_left;
        logic               cooling;
    } t_alarm_state;

    // Output transfer layout, lowest bit last
    typedef struct packed {
        logic [5:0]         pad;
        logic               maint;
        logic               locked;
        logic [DIGIT_W-1:0] digit;
        logic               buzzer;
        logic               cooler;
        logic               red;
        logic               yellow;
        logic               green;
        logic [SEG_W-1:0]   segments;
    } t_panel;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // adc_sample[11:0], button_down[12], zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // segments, leds, cooler, buzzer, digit, flags
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    t_alarm_cfg   cfg;
    t_alarm_state ctl;
    t_panel       pending_panels [$];

    int errors          = 0;
    int ticks_sent      = 0;
    int active_ticks    = 0;
    int panels_checked  = 0;
    int cooldowns_done  = 0;
    int maint_entries   = 0;
    int lock_latches    = 0;
    int settings_used   = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    int cur_digit       = 0;

    temperature_alarm_lock_controller_top #(
        .ADC_RANGE           (ADC_RANGE),
        .PHASE_TICKS         (PHASE_TICKS),
        .COOLDOWN_BLINKS     (COOLDOWN_BLINKS),
        .COOLDOWN_HALF_TICKS (COOLDOWN_HALF_TICKS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_alarm_cfg make_settings(input int warn, input int alarm,
                                                  input int lock, input int long_press,
                                                  input int min_press, input int slow,
                                                  input int mid, input int fast);
        t_alarm_cfg c;
        c.warn       = DIGIT_W'(warn);
        c.alarm      = DIGIT_W'(alarm);
        c.lock       = DIGIT_W'(lock);
        c.long_press = PRESS_W'(long_press);
        c.min_press  = PRESS_W'(min_press);
        c.slow       = BLINK_W'(slow);
        c.mid        = BLINK_W'(mid);
        c.fast       = BLINK_W'(fast);
        return c;
    endfunction

    function automatic t_alarm_cfg random_settings();
        int lp;
        lp = $urandom_range(120, 4);
        return make_settings($urandom_range(9), $urandom_range(9), $urandom_range(9), lp,
                             $urandom_range(20), $urandom_range(24, 1),
                             $urandom_range(24, 1), $urandom_range(24, 1));
    endfunction

    // Sample inside digit d: pick 0 = lowest, 1 = highest, else random
    function automatic logic [SAMPLE_W-1:0] digit_sample(input int d, input int pick);
        int lo;
        int hi;
        lo = (d * ADC_RANGE + 9) / 10;
        hi = (d == 9) ? ADC_RANGE - 1 : ((d + 1) * ADC_RANGE + 9) / 10 - 1;
        if (pick == 0)
            return SAMPLE_W'(lo);
        else if (pick == 1)
            return SAMPLE_W'(hi);
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    // One 1 ms tick: phase timer and button handling first, then display, LEDs and buzzer
    function automatic t_panel predict_tick(input logic [SAMPLE_W-1:0] sample,
                                            input logic btn);
        int unsigned        scaled;
        logic [DIGIT_W-1:0] digit;
        logic [BLINK_W-1:0] half;
        logic               sound;
        logic               was_locked;
        t_panel             r;
        r          = '0;
        sound      = 1'b0;
        was_locked = ctl.locked;
        scaled     = (int'(sample) * 10) / ADC_RANGE;
        digit      = (scaled > 9) ? 4'd9 : scaled[DIGIT_W-1:0];

        // phase timer
        ctl.phase_cnt = ctl.phase_cnt + 1'b1;
        if (ctl.phase_cnt >= PHASE_TICKS) begin
            ctl.phase_cnt  = '0;
            ctl.phase_half = ~ctl.phase_half;
        end

        // button
        if (ctl.cooling) begin
            ctl.press      = '0;
            ctl.long_taken = 1'b0;
        end else if (btn) begin
            if (ctl.press != PRESS_MAX)
                ctl.press = ctl.press + 1'b1;
            if (!ctl.long_taken && ctl.press > cfg.long_press) begin
                ctl.long_taken = 1'b1;
                ctl.maint      = ~ctl.maint;
                ctl.locked     = 1'b0;
                ctl.muted      = 1'b0;
                if (ctl.maint)
                    maint_entries++;
            end
        end else begin
            if (ctl.press != 0 && !ctl.long_taken && ctl.press > cfg.min_press
                    && !ctl.maint) begin
                if (ctl.locked) begin
                    if (digit < cfg.alarm) begin
                        ctl.cooling   = 1'b1;
                        ctl.cool_left = 12'(2 * COOLDOWN_BLINKS);
                        ctl.blink_cnt = '0;
                        ctl.blink_on  = 1'b1;
                    end
                end else begin
                    ctl.muted = ~ctl.muted;
                end
            end
            ctl.press      = '0;
            ctl.long_taken = 1'b0;
        end

        // display and outputs
        if (ctl.cooling) begin
            r.segments    = ctl.blink_on ? SEG_C : SEG_BLANK;
            r.cooler      = 1'b1;
            ctl.blink_cnt = ctl.blink_cnt + 1'b1;
            if (ctl.blink_cnt >= COOLDOWN_HALF_TICKS) begin
                ctl.blink_cnt = '0;
                ctl.blink_on  = ~ctl.blink_on;
                if (ctl.cool_left != 0)
                    ctl.cool_left = ctl.cool_left - 1'b1;
                if (ctl.cool_left == 0) begin
                    ctl.cooling  = 1'b0;
                    ctl.locked   = 1'b0;
                    ctl.muted    = 1'b0;
                    ctl.blink_on = 1'b0;
                    cooldowns_done++;
                end
            end
        end else if (ctl.maint) begin
            r.segments = SEG_DASH;
            r.yellow   = ~ctl.phase_half;
        end else begin
            if (digit >= cfg.lock)
                ctl.locked = 1'b1;
            if (ctl.locked)
                r.segments = ctl.phase_half ? SEG_BLANK : SEG_L;
            else
                r.segments = DIGIT_PATTERN[digit];
            if (digit >= cfg.alarm || ctl.locked) begin
                r.cooler = 1'b1;
                half     = cfg.slow;
                if (digit == 4'd8)
                    half = cfg.mid;
                if (digit >= cfg.lock || ctl.locked)
                    half = cfg.fast;
                if (half == 0)
                    half = BLINK_W'(1);
                ctl.blink_cnt = ctl.blink_cnt + 1'b1;
                if (ctl.blink_cnt >= half) begin
                    ctl.blink_cnt = '0;
                    ctl.blink_on  = ~ctl.blink_on;
                end
                if (ctl.blink_on) begin
                    r.red = 1'b1;
                    sound = ~ctl.muted;
                end
            end else if (digit >= cfg.warn) begin
                r.yellow  = 1'b1;
                ctl.muted = 1'b0;
            end else begin
                r.green   = 1'b1;
                ctl.muted = 1'b0;
            end
        end

        ctl.buzz = sound ? ~ctl.buzz : 1'b0;
        if (!was_locked && ctl.locked)
            lock_latches++;

        r.buzzer = ctl.buzz;
        r.digit  = digit;
        r.locked = ctl.locked;
        r.maint  = ctl.maint;
        return r;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            note_error($sformatf("panel %0d %s: expected %0d, actual %0d",
                                 panels_checked, name, want, got));
    endtask

    // Result side: compare each transfer with the oldest predicted panel
    always @(posedge i_clk) begin : check_panels
        t_panel got;
        t_panel want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_panels.size() == 0) begin
                note_error($sformatf("unexpected result: expected none, actual %h", got));
            end else begin
                want = pending_panels.pop_front();
                check_field("segments", want.segments, got.segments);
                check_field("green_led", want.green, got.green);
                check_field("yellow_led", want.yellow, got.yellow);
                check_field("red_led", want.red, got.red);
                check_field("cooler_on", want.cooler, got.cooler);
                check_field("buzzer", want.buzzer, got.buzzer);
                check_field("level_digit", want.digit, got.digit);
                check_field("locked_flag", want.locked, got.locked);
                check_field("maintenance_flag", want.maint, got.maint);
                check_field("pad", want.pad, got.pad);
                panels_checked++;
            end
        end
    end

    // Result side ready: random stalls, or a counted hold-off when requested
    initial begin : drive_ready
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic send_tick(input logic [SAMPLE_W-1:0] sample, input logic btn);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - SAMPLE_W - 1){1'b0}}, btn, sample};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (!ctl.cooling)
            active_ticks++;
        ticks_sent++;
        pending_panels.push_back(predict_tick(sample, btn));
    endtask

    task automatic run_ticks(input int n, input int d);
        repeat (n) send_tick(digit_sample(d, 2), 1'b0);
    endtask

    // Hold the button for len ticks, then release on one more tick
    task automatic press(input int len, input int d);
        repeat (len) send_tick(digit_sample(d, 2), 1'b1);
        send_tick(digit_sample(d, 2), 1'b0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_panels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_WARN_LEVEL:   cfg.warn       = value[DIGIT_W-1:0];
            CFG_ALARM_LEVEL:  cfg.alarm      = value[DIGIT_W-1:0];
            CFG_LOCK_LEVEL:   cfg.lock       = value[DIGIT_W-1:0];
            CFG_LONG_PRESS:   cfg.long_press = value;
            CFG_MIN_PRESS:    cfg.min_press  = value;
            CFG_SLOW_BLINK:   cfg.slow       = value[BLINK_W-1:0];
            CFG_MEDIUM_BLINK: cfg.mid        = value[BLINK_W-1:0];
            CFG_FAST_BLINK:   cfg.fast       = value[BLINK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input t_alarm_cfg c);
        drain_results();
        write_reg(CFG_WARN_LEVEL, c.warn);
        write_reg(CFG_ALARM_LEVEL, c.alarm);
        write_reg(CFG_LOCK_LEVEL, c.lock);
        write_reg(CFG_LONG_PRESS, c.long_press);
        write_reg(CFG_MIN_PRESS, c.min_press);
        write_reg(CFG_SLOW_BLINK, c.slow);
        write_reg(CFG_MEDIUM_BLINK, c.mid);
        write_reg(CFG_FAST_BLINK, c.fast);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic set_flow(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
    endtask

    // Bounds of every digit, bit patterns of the sample, lock at the top digit
    task automatic test_directed_extremes();
        for (int d = 0; d < 10; d++) begin
            send_tick(digit_sample(d, 0), 1'b0);
            send_tick(digit_sample(d, 1), 1'b1);
        end
        send_tick(12'hAAA, 1'b1);
        send_tick(12'h555, 1'b0);
        send_tick(12'hFFF, 1'b1);
        send_tick(12'h000, 1'b0);
    endtask

    // Locked: refused while hot, bounce ignored, cooldown to unlock,
    // long press into and out of maintenance
    task automatic test_lock_cooldown();
        run_ticks(10, 9);
        press(6, 6);
        run_ticks(10, 2);
        press(2, 2);
        press(6, 2);
        // button and temperature are ignored until the cooldown ends
        while (ctl.cooling)
            send_tick(SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
        run_ticks(10, 1);
        run_ticks(5, 8);
        press(cfg.long_press + 5, 8);
        press(6, 9);
        run_ticks(600, 9);
        press(cfg.long_press + 2, 2);
        run_ticks(10, 3);
    endtask

    // Mute toggling under alarm, mute clearing when cool, bounce filtering
    task automatic test_press_actions();
        run_ticks(30, 6);
        press(5, 6);
        run_ticks(20, 6);
        run_ticks(5, 4);
        run_ticks(20, 6);
        press(cfg.min_press, 6);
        run_ticks(10, 6);
        press(cfg.min_press + 1, 6);
        run_ticks(10, 0);
    endtask

    // With the long threshold at its top a press never turns long, and the
    // counter stops at its ceiling; release then acts as a short press
    task automatic test_press_saturation();
        drain_results();
        write_reg(CFG_LONG_PRESS, PRESS_MAX);
        i_cfg_we <= 1'b0;
        press(4100, 6);
        run_ticks(20, 6);
    endtask

    // Receiver holds off while ticks keep coming, so the input side stalls
    task automatic test_backpressure();
        hold_left = 400;
        repeat (60) send_tick(SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
    endtask

    // Temperature walks, presses of every class, noise and jumps to extremes
    task automatic test_random_sequences(input int n);
        int start;
        int pick;
        int len;
        int lo;
        int hi;
        start = active_ticks;
        while (active_ticks - start < n) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                if ($urandom_range(3) == 0)
                    cur_digit = $urandom_range(9);
                else if ($urandom_range(1) && cur_digit < 9)
                    cur_digit++;
                else if (cur_digit > 0)
                    cur_digit--;
                run_ticks($urandom_range(12, 1), cur_digit);
            end else if (pick < 72) begin
                // bounce, short or long, as far as the thresholds allow
                case ($urandom_range(2))
                    0: begin
                        hi  = (cfg.min_press > 60) ? 60 : cfg.min_press;
                        len = $urandom_range((hi < 1) ? 1 : hi, 1);
                    end
                    1: begin
                        lo  = cfg.min_press + 1;
                        hi  = (cfg.long_press < lo + 60) ? cfg.long_press : lo + 60;
                        len = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(8, 1);
                    end
                    default: begin
                        len = (cfg.long_press < 200) ? cfg.long_press + $urandom_range(8, 1)
                                                     : $urandom_range(8, 1);
                    end
                endcase
                press(len, cur_digit);
            end else if (pick < 88) begin
                repeat ($urandom_range(8, 1))
                    send_tick(SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
            end else begin
                send_tick(digit_sample($urandom_range(9), $urandom_range(1)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    initial begin : run_tests
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WARN_LEVEL;
        i_cfg_data    <= '0;
        cfg = make_settings(4, 7, 9, 2000, 50, 500, 200, 60);
        ctl = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no idling, reset values then a mid setting
        set_flow(0, 0);
        test_directed_extremes();
        write_settings(make_settings(3, 5, 8, 40, 3, 7, 4, 2));
        test_lock_cooldown();
        test_press_actions();
        test_press_saturation();

        // sender idle most of the time; lowest extremes, half period zero
        write_settings(make_settings(0, 0, 0, 1, 0, 0, 1, 0));
        set_flow(84, 0);
        test_random_sequences(250);
        write_settings(random_settings());
        test_random_sequences(150);

        // receiver stalling most of the time
        write_settings(random_settings());
        set_flow(0, 84);
        test_random_sequences(250);
        test_backpressure();

        // both sides idle now and then; highest extremes first
        write_settings(make_settings(9, 9, 9, 4095, 4095, 511, 511, 511));
        set_flow(23, 23);
        test_random_sequences(100);
        write_settings(random_settings());
        test_random_sequences(250);

        drain_results();
        $display("Covered %0d ticks (%0d panels checked) under 4 flow phases, %0d settings.",
                 ticks_sent, panels_checked, settings_used);
        $display("Lock latches %0d, cooldowns completed %0d, maintenance entries %0d.",
                 lock_latches, cooldowns_done, maint_entries);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
